FILE: rtl/core/sipq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted insert priority queue.
package sipq_pkg;

    localparam int DEPTH         = 64;
    localparam int KEY_WIDTH     = 8;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int CNT_W         = $clog2(DEPTH + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry item;
    } t_cell_cmd;

endpackage

FILE: rtl/core/sipq_cell.sv
`timescale 1ns / 1ps
// One queue cell: holds one entry, compares it with the new key and shifts.
module sipq_cell (
    input  logic               i_clk,
    input  sipq_pkg::t_cell_cmd i_cmd,
    input  sipq_pkg::t_entry   i_prev,
    input  logic               i_prev_le,
    input  logic               i_prev_occ,
    input  sipq_pkg::t_entry   i_next,
    input  logic               i_occ,
    output sipq_pkg::t_entry   o_entry,
    output logic               o_le
);
    import sipq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // cells are ordered largest key first; new entry goes ahead of equal keys
    assign o_le    = i_occ && (r_entry.key <= i_cmd.item.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_prev_le) begin
                n_entry = i_prev;
            end else if (o_le || (!i_occ && i_prev_occ)) begin
                n_entry = i_cmd.item;
            end
        end else if (i_cmd.rem) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: rtl/core/sorted_insert_priority_queue_top.sv
`timescale 1ns / 1ps
// Sorted insert priority queue, top level: a row of DEPTH cells, largest key in cell 0.
// The result beat is registered and becomes valid in the cycle after the input beat is accepted.
// Throughput: one insert or remove per cycle while o_ready is high; every cell compares and shifts at once.
// Reset (synchronous, active low) empties the queue and clears the output valid;
// cell contents and output data are not reset.
module sorted_insert_priority_queue_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_command,
    input  logic [sipq_pkg::KEY_WIDTH-1:0]     i_entry_key,
    input  logic [sipq_pkg::PAYLOAD_WIDTH-1:0] i_entry_payload,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [sipq_pkg::KEY_WIDTH-1:0]     o_out_key,
    output logic [sipq_pkg::PAYLOAD_WIDTH-1:0] o_out_payload,
    output logic                               o_out_valid,
    output logic [1:0]                         o_status,
    output logic [sipq_pkg::CNT_W-1:0]         o_occupancy
);
    import sipq_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_o_valid;
    logic [KEY_WIDTH-1:0]     r_o_key;
    logic [PAYLOAD_WIDTH-1:0] r_o_payload;
    logic                     r_o_out_valid;
    t_status                  r_o_status;
    logic [CNT_W-1:0]         r_o_occ;

    logic      w_accept;
    logic      w_is_rem;
    logic      w_full;
    logic      w_empty;
    t_cell_cmd w_cmd;
    t_status   w_status;

    t_entry w_entry [DEPTH];
    logic   w_le    [DEPTH];
    logic   w_occ   [DEPTH];

    assign o_ready  = !r_o_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_is_rem = (i_command == CMD_REMOVE);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_cmd.ins          = w_accept && !w_is_rem && !w_full;
    assign w_cmd.rem          = w_accept && w_is_rem && !w_empty;
    assign w_cmd.item.key     = i_entry_key;
    assign w_cmd.item.payload = i_entry_payload;

    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        if (w_cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.rem) begin
            n_count = r_count - 1'b1;
        end
        if (w_is_rem && w_empty) begin
            w_status = ST_EMPTY;
        end else if (!w_is_rem && w_full) begin
            w_status = ST_FULL;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            t_entry w_prev;
            logic   w_prev_le;
            logic   w_prev_occ;
            t_entry w_next;

            assign w_occ[gi] = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_first
                assign w_prev     = w_cmd.item;
                assign w_prev_le  = 1'b0;
                assign w_prev_occ = 1'b1;
            end else begin : g_mid
                assign w_prev     = w_entry[gi-1];
                assign w_prev_le  = w_le[gi-1];
                assign w_prev_occ = w_occ[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_next = w_entry[gi];
            end else begin : g_inner
                assign w_next = w_entry[gi+1];
            end

            sipq_cell u_cell (
                .i_clk      (i_clk),
                .i_cmd      (w_cmd),
                .i_prev     (w_prev),
                .i_prev_le  (w_prev_le),
                .i_prev_occ (w_prev_occ),
                .i_next     (w_next),
                .i_occ      (w_occ[gi]),
                .o_entry    (w_entry[gi]),
                .o_le       (w_le[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_o_key       <= w_cmd.rem ? w_entry[0].key : '0;
            r_o_payload   <= w_cmd.rem ? w_entry[0].payload : '0;
            r_o_out_valid <= w_cmd.rem;
            r_o_status    <= w_status;
            r_o_occ       <= n_count;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_key     = r_o_key;
    assign o_out_payload = r_o_payload;
    assign o_out_valid   = r_o_out_valid;
    assign o_status      = r_o_status;
    assign o_occupancy   = r_o_occ;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("queue count changed without a beat");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_rem && w_full) |=>
            (r_o_status == ST_FULL && r_count == CNT_W'(DEPTH)))
        else $error("insert into full queue not dropped");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_out_valid) |-> (r_o_status == ST_OK))
        else $error("popped entry with error status");

endmodule
